[hw/rtl/est_pkg.sv]
// ----------------------------------------------------------------------------
// est_pkg: exposure sequence timer package
// Command and result words, table entry layout, mode, run and event codes.
// ----------------------------------------------------------------------------
package est_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  entry_index;
    logic [23:0] entry_duration_ms;
    logic [15:0] entry_hard_power;
    logic [15:0] entry_soft_power;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [1:0]  run_state;
    logic [23:0] remaining_ms;
    logic        leds_on;
    logic [15:0] drive_hard_power;
    logic [15:0] drive_soft_power;
    logic [2:0]  event_res;
  } res_t;

  typedef struct packed {
    logic [23:0] duration;
    logic [15:0] hard_power;
    logic [15:0] soft_power;
  } entry_t;

  localparam logic [2:0] ModeTick    = 3'd0;
  localparam logic [2:0] ModeStart   = 3'd1;
  localparam logic [2:0] ModePause   = 3'd2;
  localparam logic [2:0] ModeSkip    = 3'd3;
  localparam logic [2:0] ModeCancel  = 3'd4;
  localparam logic [2:0] ModeLoad    = 3'd5;
  localparam logic [2:0] ModeRestart = 3'd6;

  localparam logic [1:0] RunIdle     = 2'd0;
  localparam logic [1:0] RunExposing = 2'd1;
  localparam logic [1:0] RunPaused   = 2'd2;

  localparam logic [2:0] EvNone      = 3'd0;
  localparam logic [2:0] EvAdvanced  = 3'd1;
  localparam logic [2:0] EvComplete  = 3'd2;
  localparam logic [2:0] EvCancelled = 3'd3;
  localparam logic [2:0] EvSkipped   = 3'd4;

  localparam logic [23:0] PauseMarginMs = 24'd50;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StExec  = 5'b00010,
    StScan  = 5'b00100,
    StFetch = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

endpackage

[hw/rtl/exposure_sequence_timer.sv]
// ----------------------------------------------------------------------------
// exposure_sequence_timer: multi-step enlarger exposure program controller
// Sequencing: each accepted word goes through the Exec, Fetch and Emit
//   states, with done_o high in Emit; when a phase ends, Scan examines table
//   entries one at a time before Fetch (up to NUM_PHASES - 1 of them).
// Flow: one word at a time; busy stays high through the result cycle,
//   so no word is taken until the last is done. The receiver cannot stall.
// Reset: asynchronous, clears run state, phase, elapsed time and the table
//   valid bits at once; entries not yet loaded read as zero.
// ----------------------------------------------------------------------------
module exposure_sequence_timer import est_pkg::*; #(
  parameter int NUM_PHASES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output res_t res_o
);

  localparam int AW = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

  state_e           state_q, state_d;
  cmd_t             cmd_q;
  logic [AW-1:0]    phase_q, phase_d;
  logic [AW-1:0]    scan_q, scan_d;
  logic [1:0]       run_q, run_d;
  logic [23:0]      elapsed_q, elapsed_d;
  logic [2:0]       ev_q, ev_d;

  entry_t           mem_q [NUM_PHASES];
  logic [NUM_PHASES-1:0] vld_q;
  entry_t           rd_q;
  logic             rd_vld_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;

  logic [23:0]      cur_dur;
  logic [23:0]      elapsed_inc;
  logic [AW:0]      phase_nxt;
  logic [AW:0]      scan_nxt;
  logic             finish;
  logic             idx_ok;

  assign cur_dur     = rd_vld_q ? rd_q.duration : 24'd0;
  assign elapsed_inc = elapsed_q + 24'd1;
  assign phase_nxt   = {1'b0, phase_q} + {{AW{1'b0}}, 1'b1};
  assign scan_nxt    = {1'b0, scan_q} + {{AW{1'b0}}, 1'b1};
  assign idx_ok      = ({28'd0, cmd_q.entry_index} < 32'(NUM_PHASES));
  assign wr_addr     = AW'(cmd_q.entry_index);
  assign wr_data     = '{duration:   cmd_q.entry_duration_ms,
                         hard_power: cmd_q.entry_hard_power,
                         soft_power: cmd_q.entry_soft_power};

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    scan_d    = scan_q;
    run_d     = run_q;
    elapsed_d = elapsed_q;
    ev_d      = ev_q;
    rd_en     = 1'b0;
    rd_addr   = phase_q;
    wr_en     = 1'b0;
    finish    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          rd_en   = 1'b1;
          ev_d    = EvNone;
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StFetch;
        case (cmd_q.mode)
          ModeTick: begin
            if (run_q == RunExposing) begin
              elapsed_d = elapsed_inc;
              finish    = (elapsed_inc >= cur_dur);
            end
          end
          ModeStart: begin
            if (run_q == RunIdle) begin
              elapsed_d = 24'd0;
              if (cur_dur == 24'd0) finish = 1'b1;
              else run_d = RunExposing;
            end
          end
          ModePause: begin
            if (run_q == RunExposing) begin
              if (cur_dur > elapsed_q && (cur_dur - elapsed_q) > PauseMarginMs) begin
                run_d = RunPaused;
              end
            end else if (run_q == RunPaused) begin
              run_d = RunExposing;
            end
          end
          ModeSkip: begin
            if (run_q == RunPaused) finish = 1'b1;
          end
          ModeCancel: begin
            if (run_q == RunPaused) begin
              run_d     = RunIdle;
              elapsed_d = 24'd0;
              phase_d   = '0;
              ev_d      = EvCancelled;
            end
          end
          ModeLoad: begin
            if (run_q == RunIdle && idx_ok) wr_en = 1'b1;
          end
          ModeRestart: begin
            run_d     = RunIdle;
            elapsed_d = 24'd0;
            phase_d   = '0;
          end
          default: ;
        endcase
        if (finish) begin
          run_d     = RunIdle;
          elapsed_d = 24'd0;
          if (phase_nxt < (AW+1)'(NUM_PHASES)) begin
            scan_d  = phase_nxt[AW-1:0];
            rd_en   = 1'b1;
            rd_addr = phase_nxt[AW-1:0];
            state_d = StScan;
          end else begin
            phase_d = '0;
            ev_d    = EvComplete;
          end
        end
      end
      StScan: begin
        if (cur_dur != 24'd0) begin
          phase_d = scan_q;
          ev_d    = (cmd_q.mode == ModeSkip) ? EvSkipped : EvAdvanced;
          state_d = StFetch;
        end else if (scan_nxt < (AW+1)'(NUM_PHASES)) begin
          scan_d  = scan_nxt[AW-1:0];
          rd_en   = 1'b1;
          rd_addr = scan_nxt[AW-1:0];
        end else begin
          phase_d = '0;
          ev_d    = EvComplete;
          state_d = StFetch;
        end
      end
      StFetch: begin
        rd_en   = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      phase_q   <= '0;
      scan_q    <= '0;
      run_q     <= RunIdle;
      elapsed_q <= 24'd0;
      ev_q      <= EvNone;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      scan_q    <= scan_d;
      run_q     <= run_d;
      elapsed_q <= elapsed_d;
      ev_q      <= ev_d;
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_q <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) cmd_q <= cmd_i;
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // Drive the result from the entry of the settled phase.
  always_comb begin
    res_o.phase     = 4'(phase_q);
    res_o.run_state = run_q;
    if (run_q == RunIdle) begin
      res_o.remaining_ms = cur_dur;
    end else begin
      res_o.remaining_ms = (cur_dur > elapsed_q) ? cur_dur - elapsed_q : 24'd0;
    end
    res_o.leds_on          = (run_q == RunExposing);
    res_o.drive_hard_power = (run_q == RunExposing && rd_vld_q) ? rd_q.hard_power : 16'd0;
    res_o.drive_soft_power = (run_q == RunExposing && rd_vld_q) ? rd_q.soft_power : 16'd0;
    res_o.event_res        = ev_q;
  end

  assign done_o = (state_q == StEmit);
  assign busy   = (state_q != StIdle);

endmodule
